// ===== design/cvr_pkg.sv =====
package cvr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NRM_BITS      = 14;
	localparam int BNC_ONE       = 65536;
	// quotient bits of the exchange divide: the delta stays below 2^36
	localparam int EXC_QW        = 37;
	// remainder widths of the friction and exchange dividers
	localparam int FRIC_DW       = 56;
	localparam int EXC_DW        = 33;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_PAIR   = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] pvx;
		logic signed [31:0] pvy;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic               mov;
		logic               rest;
	} base_t;

	// everything that rides alongside the exchange divider
	typedef struct packed {
		logic               v;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] pvx;
		logic signed [31:0] pvy;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic               k1;
		logic               k2;
		logic               mok;
		logic               mz;
		logic signed [36:0] tx;
		logic signed [36:0] ty;
		logic signed [38:0] bx;
		logic signed [38:0] by;
	} side_t;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		kind_t              kind;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

// ===== design/cvr_div.sv =====
module cvr_div #(
	parameter int DW = cvr_pkg::EXC_DW,
	parameter int IT = cvr_pkg::EXC_QW
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem,
	input  logic [IT-1:0] bits,
	input  logic [DW-1:0] den,
	output logic [IT-1:0] quo
);

	logic [DW-1:0] rem_q  [IT];
	logic [DW-1:0] den_q  [IT];
	logic [IT-1:0] bits_q [IT];
	logic [IT-1:0] quo_q  [IT];

	for (genvar k = 0; k < IT; k++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [IT-1:0] b_in;
		logic [IT-1:0] q_in;
		logic [DW:0]   r2;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = rem;
			assign d_in = den;
			assign b_in = bits;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign d_in = den_q[k-1];
			assign b_in = bits_q[k-1];
			assign q_in = quo_q[k-1];
		end

		// bring down one dividend bit, subtract when it fits
		assign r2 = {r_in, b_in[IT-1]};
		assign ge = r2 >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? DW'(r2 - {1'b0, d_in}) : r2[DW-1:0];
				den_q[k]  <= d_in;
				bits_q[k] <= b_in << 1;
				quo_q[k]  <= {q_in[IT-2:0], ge};
			end
		end
	end

	assign quo = quo_q[IT-1];

endmodule

// ===== design/cvr_dly.sv =====
module cvr_dly #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				line_q[k] <= '0;
			end
		end else if (en) begin
			line_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule

// ===== design/collision_velocity_response_2d_unit.sv =====
// Contact velocity response. One transaction on the input channel carries one
// contact: own and partner velocity, unit normal (Q2.14), friction, bounciness,
// masses and flags. One transaction on the output channel carries the new own
// and partner velocities and the response kind.
// Both channels use valid/stall: a transaction moves at a rising edge with
// valid high and stall low.
// Latency from the accepting edge to out_valid is the same for any FRAC_BITS.
// Nine stages form the dot products, magnitudes and the 100-bit exchange
// product, a 37-stage restoring divider (one quotient bit per stage) produces
// the exchange deltas, three stages apply them and saturate, then the output
// register. The friction divide runs alongside, one bit per stage.
// Throughput: one contact per cycle while in_stall is low.
// Stall: a stalled result holds in the output register; one more result lands
// in a skid register, and in_stall rises while the skid is full, freezing the
// whole pipeline until the output drains. Nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits; pipeline contents are discarded.
module collision_velocity_response_2d_unit #(
	parameter int FRAC_BITS = cvr_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] self_vx,
	input  logic signed [31:0] self_vy,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic [15:0]        friction_coef,
	input  logic signed [17:0] bounce_coef,
	input  logic               partner_moveable,
	input  logic signed [31:0] partner_vx,
	input  logic signed [31:0] partner_vy,
	input  logic [31:0]        self_mass,
	input  logic [31:0]        partner_mass,
	input  logic               resting_contact,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_self_vx,
	output logic signed [31:0] out_self_vy,
	output logic signed [31:0] out_partner_vx,
	output logic signed [31:0] out_partner_vy,
	output logic [1:0]         response_kind
);

	localparam int QW   = cvr_pkg::EXC_QW;
	localparam int NB   = cvr_pkg::NRM_BITS;
	localparam int FDLY = 4 + QW - FRAC_BITS;
	localparam int SW   = $bits(cvr_pkg::side_t);

	logic en;
	logic skid_v_q, out_v_q;

	assign en       = ~skid_v_q;
	assign in_stall = skid_v_q;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_e1, v_e2, v_e3;

	// stage payload
	cvr_pkg::base_t b_s1, b_s2, b_s3, b_s4, b_s5, b_s6, b_s7, b_s8, b_s9;
	logic [15:0] fr_s1, fr_s2, fr_s3, fr_s4;
	logic [16:0] e_s1, e_s2, e_s3, e_s4, e_s5;
	logic [31:0] m1_s1, m2_s1, m1_s2, m2_s2;
	logic [32:0] msum_s2, msum_s3, msum_s4, msum_s5, msum_s6, msum_s7, msum_s8, msum_s9;
	logic [17:0] onepe_s2;
	logic signed [47:0] pxn_s2, pyn_s2, pxy_s2, pyx_s2, qxn_s2, qyn_s2;
	logic signed [48:0] dn_s3, dt_s3, pdn_s3;
	logic [49:0] x1_s3, x2_s3, x1_s4, x2_s4, x1_s5, x2_s5;
	logic signed [49:0] diff_s4;
	logic k1_s4, k1_s5, k1_s6, k1_s7, k1_s8, k1_s9;
	logic k2_s5, k2_s6, k2_s7, k2_s8, k2_s9;
	logic [47:0] mdn_s4, mdt_s4;
	logic dtnz_s4, dtnz_s5;
	logic signed [64:0] tp_x_s4, np_x_s4, np_y_s4;
	logic signed [65:0] tp_y_s4;
	logic [48:0] mdiff_s5;
	logic [63:0] a_s5;
	logic [55:0] bd_s5;
	logic signed [36:0] tx_s5, ty_s5, tx_s6, ty_s6, tx_s7, ty_s7, tx_s8, ty_s8, tx_s9, ty_s9;
	logic signed [36:0] nbx_s5, nby_s5;
	logic mok_s6, mok_s7, mok_s8, mok_s9;
	logic signed [54:0] bxp_s6, byp_s6;
	logic [49:0] ll1_s6, hl1_s6, ll2_s6, hl2_s6, ll1_s7, ll2_s7;
	logic [48:0] lh1_s6, hh1_s6, lh2_s6, hh2_s6, hh1_s7, hh2_s7;
	logic [50:0] mid1_s7, mid2_s7;
	logic signed [38:0] bx_s7, by_s7, bx_s8, by_s8, bx_s9, by_s9;
	logic [99:0] p1_s8, p2_s8;
	logic [67:0] d1_s9, d2_s9;

	logic [16:0] e_clamp;
	logic signed [16:0] nnx;
	cvr_pkg::side_t side_in, sd_d, sd_e1, sd_e2;
	logic [FRAC_BITS-1:0] fq_raw, fq_d;
	logic [QW-1:0] q1, q2;

	logic [FRAC_BITS:0] mul_e1;
	logic signed [37:0] ds_e1, dp_e1;
	logic signed [FRAC_BITS+38:0] tm_x_e2, tm_y_e2;
	logic signed [53:0] nd_x_e2, nd_y_e2, np_x_e2, np_y_e2;
	cvr_pkg::res_t res_next, res_e3, res_q, skid_q;

	always_comb begin
		if (bounce_coef[17]) begin
			e_clamp = '0;
		end else if (bounce_coef > 18'sd65536) begin
			e_clamp = 17'(cvr_pkg::BNC_ONE);
		end else begin
			e_clamp = bounce_coef[16:0];
		end
	end

	assign nnx = -(17'(b_s3.nx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_e1 <= sd_d.v;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: capture
			b_s1.vx   <= self_vx;
			b_s1.vy   <= self_vy;
			b_s1.pvx  <= partner_vx;
			b_s1.pvy  <= partner_vy;
			b_s1.nx   <= normal_x;
			b_s1.ny   <= normal_y;
			b_s1.mov  <= partner_moveable;
			b_s1.rest <= resting_contact;
			fr_s1     <= friction_coef;
			e_s1      <= e_clamp;
			m1_s1     <= self_mass;
			m2_s1     <= partner_mass;

			// s2: velocity by normal products
			b_s2     <= b_s1;
			fr_s2    <= fr_s1;
			e_s2     <= e_s1;
			m1_s2    <= m1_s1;
			m2_s2    <= m2_s1;
			msum_s2  <= 33'(m1_s1) + 33'(m2_s1);
			onepe_s2 <= 18'(e_s1) + 18'(cvr_pkg::BNC_ONE);
			pxn_s2   <= b_s1.vx * b_s1.nx;
			pyn_s2   <= b_s1.vy * b_s1.ny;
			pxy_s2   <= b_s1.vx * b_s1.ny;
			pyx_s2   <= b_s1.vy * b_s1.nx;
			qxn_s2   <= b_s1.pvx * b_s1.nx;
			qyn_s2   <= b_s1.pvy * b_s1.ny;

			// s3: normal and tangent speeds, (1+e)*m
			b_s3    <= b_s2;
			fr_s3   <= fr_s2;
			e_s3    <= e_s2;
			msum_s3 <= msum_s2;
			dn_s3   <= 49'(pxn_s2) + 49'(pyn_s2);
			dt_s3   <= 49'(pxy_s2) - 49'(pyx_s2);
			pdn_s3  <= 49'(qxn_s2) + 49'(qyn_s2);
			x1_s3   <= 50'(onepe_s2) * 50'(m2_s2);
			x2_s3   <= 50'(onepe_s2) * 50'(m1_s2);

			// s4: magnitudes, tangent and normal components
			b_s4    <= b_s3;
			fr_s4   <= fr_s3;
			e_s4    <= e_s3;
			msum_s4 <= msum_s3;
			x1_s4   <= x1_s3;
			x2_s4   <= x2_s3;
			diff_s4 <= 50'(dn_s3) - 50'(pdn_s3);
			k1_s4   <= ~b_s3.mov & dn_s3[48];
			mdn_s4  <= dn_s3[48] ? 48'(-dn_s3) : 48'(dn_s3);
			mdt_s4  <= dt_s3[48] ? 48'(-dt_s3) : 48'(dt_s3);
			dtnz_s4 <= dt_s3 != '0;
			tp_x_s4 <= b_s3.ny * dt_s3;
			tp_y_s4 <= nnx * dt_s3;
			np_x_s4 <= b_s3.nx * dn_s3;
			np_y_s4 <= b_s3.ny * dn_s3;

			// s5: friction ratio terms, round components to Q.F
			b_s5     <= b_s4;
			e_s5     <= e_s4;
			msum_s5  <= msum_s4;
			x1_s5    <= x1_s4;
			x2_s5    <= x2_s4;
			k1_s5    <= k1_s4;
			dtnz_s5  <= dtnz_s4;
			k2_s5    <= b_s4.mov & diff_s4[49];
			mdiff_s5 <= diff_s4[49] ? 49'(-diff_s4) : 49'(diff_s4);
			a_s5     <= 64'(mdn_s4) * 64'(fr_s4);
			bd_s5    <= {mdt_s4, 8'd0};
			tx_s5    <= 37'(tp_x_s4 >>> (2 * NB)) + 37'(tp_x_s4[2*NB-1]);
			ty_s5    <= 37'(tp_y_s4 >>> (2 * NB)) + 37'(tp_y_s4[2*NB-1]);
			nbx_s5   <= 37'(np_x_s4 >>> (2 * NB)) + 37'(np_x_s4[2*NB-1]);
			nby_s5   <= 37'(np_y_s4 >>> (2 * NB)) + 37'(np_y_s4[2*NB-1]);

			// s6: bounce products, exchange partial products
			b_s6    <= b_s5;
			msum_s6 <= msum_s5;
			k1_s6   <= k1_s5;
			k2_s6   <= k2_s5;
			tx_s6   <= tx_s5;
			ty_s6   <= ty_s5;
			mok_s6  <= dtnz_s5 & (a_s5 < 64'(bd_s5));
			bxp_s6  <= nbx_s5 * $signed({1'b0, e_s5});
			byp_s6  <= nby_s5 * $signed({1'b0, e_s5});
			ll1_s6  <= 50'(x1_s5[24:0]) * 50'(mdiff_s5[24:0]);
			lh1_s6  <= 49'(x1_s5[24:0]) * 49'(mdiff_s5[48:25]);
			hl1_s6  <= 50'(x1_s5[49:25]) * 50'(mdiff_s5[24:0]);
			hh1_s6  <= 49'(x1_s5[49:25]) * 49'(mdiff_s5[48:25]);
			ll2_s6  <= 50'(x2_s5[24:0]) * 50'(mdiff_s5[24:0]);
			lh2_s6  <= 49'(x2_s5[24:0]) * 49'(mdiff_s5[48:25]);
			hl2_s6  <= 50'(x2_s5[49:25]) * 50'(mdiff_s5[24:0]);
			hh2_s6  <= 49'(x2_s5[49:25]) * 49'(mdiff_s5[48:25]);

			// s7: round bounce, fold middle partial products
			b_s7    <= b_s6;
			msum_s7 <= msum_s6;
			k1_s7   <= k1_s6;
			k2_s7   <= k2_s6;
			tx_s7   <= tx_s6;
			ty_s7   <= ty_s6;
			mok_s7  <= mok_s6;
			bx_s7   <= b_s6.rest ? '0 : 39'(bxp_s6 >>> 16) + 39'(bxp_s6[15]);
			by_s7   <= b_s6.rest ? '0 : 39'(byp_s6 >>> 16) + 39'(byp_s6[15]);
			mid1_s7 <= 51'(lh1_s6) + 51'(hl1_s6);
			mid2_s7 <= 51'(lh2_s6) + 51'(hl2_s6);
			ll1_s7  <= ll1_s6;
			hh1_s7  <= hh1_s6;
			ll2_s7  <= ll2_s6;
			hh2_s7  <= hh2_s6;

			// s8: full exchange products
			b_s8    <= b_s7;
			msum_s8 <= msum_s7;
			k1_s8   <= k1_s7;
			k2_s8   <= k2_s7;
			tx_s8   <= tx_s7;
			ty_s8   <= ty_s7;
			mok_s8  <= mok_s7;
			bx_s8   <= bx_s7;
			by_s8   <= by_s7;
			p1_s8   <= 100'({hh1_s7, ll1_s7}) + (100'(mid1_s7) << 25);
			p2_s8   <= 100'({hh2_s7, ll2_s7}) + (100'(mid2_s7) << 25);

			// s9: add half divisor, drop the 30 zero bits of the divisor
			b_s9    <= b_s8;
			msum_s9 <= msum_s8;
			k1_s9   <= k1_s8;
			k2_s9   <= k2_s8;
			tx_s9   <= tx_s8;
			ty_s9   <= ty_s8;
			mok_s9  <= mok_s8;
			bx_s9   <= bx_s8;
			by_s9   <= by_s8;
			d1_s9   <= 68'((p1_s8 + (100'(msum_s8) << 29)) >> 30);
			d2_s9   <= 68'((p2_s8 + (100'(msum_s8) << 29)) >> 30);

			// e1: friction multiplier and signed deltas (diff is negative here)
			sd_e1  <= sd_d;
			mul_e1 <= sd_d.mok ? {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fq_d} : '0;
			ds_e1  <= sd_d.mz ? '0 : -$signed({1'b0, q1});
			dp_e1  <= sd_d.mz ? '0 : -$signed({1'b0, q2});

			// e2: apply multiplier and deltas along the normal
			sd_e2   <= sd_e1;
			tm_x_e2 <= sd_e1.tx * $signed({1'b0, mul_e1});
			tm_y_e2 <= sd_e1.ty * $signed({1'b0, mul_e1});
			nd_x_e2 <= sd_e1.nx * ds_e1;
			nd_y_e2 <= sd_e1.ny * ds_e1;
			np_x_e2 <= sd_e1.nx * dp_e1;
			np_y_e2 <= sd_e1.ny * dp_e1;

			// e3: final sums, saturate
			res_e3 <= res_next;
		end
	end

	always_comb begin
		side_in.v   = v_s9;
		side_in.vx  = b_s9.vx;
		side_in.vy  = b_s9.vy;
		side_in.pvx = b_s9.pvx;
		side_in.pvy = b_s9.pvy;
		side_in.nx  = b_s9.nx;
		side_in.ny  = b_s9.ny;
		side_in.k1  = k1_s9;
		side_in.k2  = k2_s9;
		side_in.mok = mok_s9;
		side_in.mz  = msum_s9 == '0;
		side_in.tx  = tx_s9;
		side_in.ty  = ty_s9;
		side_in.bx  = bx_s9;
		side_in.by  = by_s9;
	end

	cvr_div #(.DW(cvr_pkg::FRIC_DW), .IT(FRAC_BITS)) u_fdiv (
		.clk  (clk),
		.en   (en),
		.rem  (a_s5[cvr_pkg::FRIC_DW-1:0]),
		.bits ('0),
		.den  (bd_s5),
		.quo  (fq_raw)
	);

	cvr_dly #(.W(FRAC_BITS), .N(FDLY)) u_fdly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (fq_raw),
		.q      (fq_d)
	);

	cvr_div #(.DW(cvr_pkg::EXC_DW), .IT(QW)) u_sdiv (
		.clk  (clk),
		.en   (en),
		.rem  (cvr_pkg::EXC_DW'(d1_s9[67:QW])),
		.bits (d1_s9[QW-1:0]),
		.den  (msum_s9),
		.quo  (q1)
	);

	cvr_div #(.DW(cvr_pkg::EXC_DW), .IT(QW)) u_pdiv (
		.clk  (clk),
		.en   (en),
		.rem  (cvr_pkg::EXC_DW'(d2_s9[67:QW])),
		.bits (d2_s9[QW-1:0]),
		.den  (msum_s9),
		.quo  (q2)
	);

	cvr_dly #(.W(SW), .N(QW)) u_sdly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (side_in),
		.q      (sd_d)
	);

	logic signed [40:0] s_x, s_y;
	logic signed [41:0] t_x, t_y, u_x, u_y;

	always_comb begin
		s_x = 41'(tm_x_e2 >>> FRAC_BITS) + 41'(tm_x_e2[FRAC_BITS-1]) - 41'(sd_e2.bx);
		s_y = 41'(tm_y_e2 >>> FRAC_BITS) + 41'(tm_y_e2[FRAC_BITS-1]) - 41'(sd_e2.by);
		t_x = 42'(sd_e2.vx) - 42'(nd_x_e2 >>> NB) - 42'(nd_x_e2[NB-1]);
		t_y = 42'(sd_e2.vy) - 42'(nd_y_e2 >>> NB) - 42'(nd_y_e2[NB-1]);
		u_x = 42'(sd_e2.pvx) + 42'(np_x_e2 >>> NB) + 42'(np_x_e2[NB-1]);
		u_y = 42'(sd_e2.pvy) + 42'(np_y_e2 >>> NB) + 42'(np_y_e2[NB-1]);
		res_next.sx   = sd_e2.vx;
		res_next.sy   = sd_e2.vy;
		res_next.px   = sd_e2.pvx;
		res_next.py   = sd_e2.pvy;
		res_next.kind = cvr_pkg::KIND_NONE;
		if (sd_e2.k1) begin
			res_next.sx   = cvr_pkg::sat32(64'(s_x));
			res_next.sy   = cvr_pkg::sat32(64'(s_y));
			res_next.kind = cvr_pkg::KIND_SINGLE;
		end else if (sd_e2.k2) begin
			res_next.sx   = cvr_pkg::sat32(64'(t_x));
			res_next.sy   = cvr_pkg::sat32(64'(t_y));
			res_next.px   = cvr_pkg::sat32(64'(u_x));
			res_next.py   = cvr_pkg::sat32(64'(u_y));
			res_next.kind = cvr_pkg::KIND_PAIR;
		end
	end

	// output register with one skid entry
	logic arrive, take;

	assign arrive = en & v_e3;
	assign take   = out_v_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= arrive;
			end
		end else if (arrive) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			res_q <= skid_v_q ? skid_q : res_e3;
		end else if (arrive) begin
			skid_q <= res_e3;
		end
	end

	assign out_valid      = out_v_q;
	assign out_self_vx    = res_q.sx;
	assign out_self_vy    = res_q.sy;
	assign out_partner_vx = res_q.px;
	assign out_partner_vy = res_q.py;
	assign response_kind  = res_q.kind;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a transaction while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && out_stall && v_e3))
		else $error("skid filled without a stalled output and an arriving result");
`endif

endmodule

// ===== tb/sv/collision_velocity_response_2d_unit_tb.sv =====
`timescale 1ns / 100ps

module collision_velocity_response_2d_unit_tb;

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [15:0]        fr;
		logic signed [17:0] bc;
		logic               mov;
		logic signed [31:0] pvx;
		logic signed [31:0] pvy;
		logic [31:0]        m1;
		logic [31:0]        m2;
		logic               rest;
	} contact_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] self_vx = '0;
	logic signed [31:0] self_vy = '0;
	logic signed [15:0] normal_x = '0;
	logic signed [15:0] normal_y = '0;
	logic [15:0]        friction_coef = '0;
	logic signed [17:0] bounce_coef = '0;
	logic               partner_moveable = 1'b0;
	logic signed [31:0] partner_vx = '0;
	logic signed [31:0] partner_vy = '0;
	logic [31:0]        self_mass = 32'd1;
	logic [31:0]        partner_mass = 32'd1;
	logic               resting_contact = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] out_self_vx;
	logic signed [31:0] out_self_vy;
	logic signed [31:0] out_partner_vx;
	logic signed [31:0] out_partner_vy;
	logic [1:0]         response_kind;

	cvr_pkg::res_t response_q[$];
	int   gap_pct = 0;
	int   stall_pct = 0;
	int   error_count = 0;
	int   kind_count[3] = '{0, 0, 0};
	int   sent_count = 0;

	collision_velocity_response_2d_unit u_top (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d responses outstanding", response_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic wide_t round_shift(wide_t x, int s);
		return (x + (wide_t'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(wide_t x);
		if (x > 128'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -128'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic wide_t mag(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// velocity change of one body in the exchange, rounded half away from zero
	function automatic wide_t exchange_share(wide_t p, wide_t dmag, wide_t msum);
		wide_t d;
		if (msum == 0) begin
			return 0;
		end
		d = msum <<< 30;
		return (p * dmag + (d >>> 1)) / d;
	endfunction

	function automatic cvr_pkg::res_t predict_response(contact_t c);
		wide_t vx, vy, nx, ny, pvx, pvy, fr, e, m1, m2;
		wide_t dn, dt, pdn, diff, mul, a, b, tx, ty, bx, by, ds, dp, onepe;
		wide_t ox, oy, opx, opy;
		cvr_pkg::res_t r;
		vx = c.vx; vy = c.vy; nx = c.nx; ny = c.ny;
		pvx = c.pvx; pvy = c.pvy; e = c.bc;
		fr = {112'd0, c.fr};
		m1 = {96'd0, c.m1};
		m2 = {96'd0, c.m2};
		ox = vx; oy = vy; opx = pvx; opy = pvy;
		r.kind = cvr_pkg::KIND_NONE;
		if (e < 0) e = 0;
		if (e > cvr_pkg::BNC_ONE) e = cvr_pkg::BNC_ONE;
		dn = vx * nx + vy * ny;
		if (!c.mov) begin
			if (dn < 0) begin
				dt = vx * ny - vy * nx;
				mul = 0;
				if (dt != 0) begin
					a = mag(dn) * fr;
					b = mag(dt) <<< 8;
					if (a < b) begin
						mul = (wide_t'(1) <<< cvr_pkg::FRAC_BITS_DEF)
							- ((a <<< cvr_pkg::FRAC_BITS_DEF) / b);
					end
				end
				tx = round_shift(ny * dt, 2 * cvr_pkg::NRM_BITS);
				ty = round_shift(-nx * dt, 2 * cvr_pkg::NRM_BITS);
				bx = c.rest ? 0 :
					round_shift(round_shift(nx * dn, 2 * cvr_pkg::NRM_BITS) * e, 16);
				by = c.rest ? 0 :
					round_shift(round_shift(ny * dn, 2 * cvr_pkg::NRM_BITS) * e, 16);
				ox = round_shift(tx * mul, cvr_pkg::FRAC_BITS_DEF) - bx;
				oy = round_shift(ty * mul, cvr_pkg::FRAC_BITS_DEF) - by;
				r.kind = cvr_pkg::KIND_SINGLE;
			end
		end else begin
			pdn = pvx * nx + pvy * ny;
			diff = dn - pdn;
			if (diff < 0) begin
				onepe = cvr_pkg::BNC_ONE + e;
				ds = -exchange_share(onepe * m2, -diff, m1 + m2);
				dp = -exchange_share(onepe * m1, -diff, m1 + m2);
				ox = vx - round_shift(nx * ds, cvr_pkg::NRM_BITS);
				oy = vy - round_shift(ny * ds, cvr_pkg::NRM_BITS);
				opx = pvx + round_shift(nx * dp, cvr_pkg::NRM_BITS);
				opy = pvy + round_shift(ny * dp, cvr_pkg::NRM_BITS);
				r.kind = cvr_pkg::KIND_PAIR;
			end
		end
		r.sx = clamp32(ox);
		r.sy = clamp32(oy);
		r.px = clamp32(opx);
		r.py = clamp32(opy);
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		cvr_pkg::res_t want;
		if (out_valid && !out_stall) begin
			if (response_q.size() == 0) begin
				report_mismatch("unexpected transaction", {30'd0, response_kind}, 32'd0);
			end else begin
				want = response_q.pop_front();
				if (out_self_vx !== want.sx) report_mismatch("out_self_vx", out_self_vx, want.sx);
				if (out_self_vy !== want.sy) report_mismatch("out_self_vy", out_self_vy, want.sy);
				if (out_partner_vx !== want.px)
					report_mismatch("out_partner_vx", out_partner_vx, want.px);
				if (out_partner_vy !== want.py)
					report_mismatch("out_partner_vy", out_partner_vy, want.py);
				if (response_kind !== want.kind)
					report_mismatch("response_kind", {30'd0, response_kind}, {30'd0, want.kind});
				if (want.kind <= cvr_pkg::KIND_PAIR) kind_count[want.kind]++;
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_contact(input contact_t c);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		self_vx          <= c.vx;
		self_vy          <= c.vy;
		normal_x         <= c.nx;
		normal_y         <= c.ny;
		friction_coef    <= c.fr;
		bounce_coef      <= c.bc;
		partner_moveable <= c.mov;
		partner_vx       <= c.pvx;
		partner_vy       <= c.pvy;
		self_mass        <= c.m1;
		partner_mass     <= c.m2;
		resting_contact  <= c.rest;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		response_q.push_back(predict_response(c));
		sent_count++;
	endtask

	// drop valid and let the pipeline empty
	task automatic drain;
		in_valid <= 1'b0;
		while (response_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic contact_t make_contact(logic signed [31:0] vx, logic signed [31:0] vy,
			logic signed [15:0] nx, logic signed [15:0] ny, logic [15:0] fr,
			logic signed [17:0] bc, logic mov, logic signed [31:0] pvx,
			logic signed [31:0] pvy, logic [31:0] m1, logic [31:0] m2, logic rest);
		contact_t c;
		c = '{vx, vy, nx, ny, fr, bc, mov, pvx, pvy, m1, m2, rest};
		return c;
	endfunction

	task automatic test_passthrough;
		send_contact(make_contact(32'sd65536, -32'sd70000, 16'sd0, 16'sd0, 16'd256, 18'sd65536,
			1'b0, 32'sd5, 32'sd6, 32'd65536, 32'd65536, 1'b0));
		send_contact(make_contact(32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'd256, 18'sd65536,
			1'b0, 32'sd0, 32'sd0, 32'd65536, 32'd65536, 1'b0));
		send_contact(make_contact(32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'd256, 18'sd32768,
			1'b1, -32'sd65536, 32'sd0, 32'd65536, 32'd65536, 1'b0));
		send_contact(make_contact(32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'd0, 18'sd0,
			1'b1, 32'sd0, 32'sd0, 32'd0, 32'd0, 1'b0));
	endtask

	task automatic test_single_body;
		// head-on, no tangent speed
		send_contact(make_contact(-32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'd512, 18'sd32768,
			1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd40000, 16'sd16384, 16'sd0, 16'd0, 18'sd65536,
			1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd40000, 16'sd16384, 16'sd0, 16'd128,
			18'sd49152, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd40000, 16'sd16384, 16'sd0, 16'hffff,
			18'sd49152, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd40000, 16'sd0, 16'sd16384, 16'd64,
			18'sd49152, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b1));
		// bounciness below zero and above one
		send_contact(make_contact(32'sd90000, -32'sd30000, -16'sd11585, 16'sd11585, 16'd64,
			-18'sd131072, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		send_contact(make_contact(32'sd90000, -32'sd30000, -16'sd11585, 16'sd11585, 16'd64,
			18'sd131071, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		// extreme speeds, saturation
		send_contact(make_contact(32'sh80000000, 32'sh7fffffff, 16'sd16384, -16'sd16384, 16'd1,
			18'sd65536, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		send_contact(make_contact(32'sh80000000, 32'sh80000000, 16'sd16384, 16'sd16384, 16'd0,
			18'sd65536, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
		// non-unit normal
		send_contact(make_contact(-32'sd200000, 32'sd7, 16'sd3000, -16'sd500, 16'd300,
			18'sd20000, 1'b0, 32'sd0, 32'sd0, 32'd1, 32'd1, 1'b0));
	endtask

	task automatic test_two_body;
		send_contact(make_contact(-32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'd0, 18'sd65536,
			1'b1, 32'sd65536, 32'sd0, 32'd65536, 32'd65536, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd1000, 16'sd11585, 16'sd11585, 16'd0,
			18'sd0, 1'b1, 32'sd300, 32'sd65536, 32'd65536, 32'd262144, 1'b1));
		send_contact(make_contact(32'sh80000000, 32'sh80000000, 16'sd16384, 16'sd16384, 16'd0,
			18'sd131071, 1'b1, 32'sh7fffffff, 32'sh7fffffff, 32'hffffffff, 32'hffffffff, 1'b0));
		send_contact(make_contact(32'sh80000000, 32'sd0, 16'sd16384, 16'sd0, 16'd0,
			-18'sd5, 1'b1, 32'sh7fffffff, 32'sd0, 32'd1, 32'hffffffff, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'd0, 18'sd65536,
			1'b1, 32'sd65536, 32'sd0, 32'd0, 32'd0, 1'b0));
		send_contact(make_contact(-32'sd65536, 32'sd0, 16'sd16384, 16'sd0, 16'd0, 18'sd65536,
			1'b1, 32'sd65536, 32'sd0, 32'd0, 32'd5, 1'b0));
	endtask

	function automatic logic signed [31:0] rand_speed;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2000000)) - 32'sd1000000;
			default: return $signed($urandom_range(600000)) - 32'sd300000;
		endcase
	endfunction

	function automatic contact_t rand_contact;
		contact_t c;
		int k;
		logic signed [15:0] unit_x[8] = '{16384, 0, -16384, 0, 11585, -11585, 11585, -11585};
		logic signed [15:0] unit_y[8] = '{0, 16384, 0, -16384, 11585, 11585, -11585, -11585};
		k = $urandom_range(7);
		c.vx = rand_speed();
		c.vy = rand_speed();
		c.pvx = rand_speed();
		c.pvy = rand_speed();
		if ($urandom_range(9) < 7) begin
			c.nx = unit_x[k];
			c.ny = unit_y[k];
			c.bc = 18'($urandom_range(65536));
			c.fr = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(512));
			c.m1 = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1, 1 << 20));
			c.m2 = $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(1, 1 << 20));
		end else begin
			c.nx = 16'($signed($urandom_range(32768)) - 32'sd16384);
			c.ny = 16'($signed($urandom_range(32768)) - 32'sd16384);
			c.bc = 18'($urandom);
			c.fr = 16'($urandom);
			c.m1 = $urandom;
			c.m2 = $urandom;
		end
		if ($urandom_range(7) == 0) c.vy = 32'($signed(c.vx) * 0);
		c.mov = 1'($urandom_range(1));
		c.rest = 1'($urandom_range(1));
		return c;
	endfunction

	task automatic test_random(input int count);
		repeat (count) send_contact(rand_contact());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 19;
		stall_pct = 51;
		test_passthrough();
		test_single_body();
		test_two_body();
		test_random(140);
		drain();
		gap_pct = 51;
		stall_pct = 19;
		test_random(140);
		drain();
		gap_pct = 0;
		stall_pct = 0;
		test_random(150);
		drain();
		$display("%0d contacts sent: %0d passed through, %0d single-body, %0d two-body",
			sent_count, kind_count[0], kind_count[1], kind_count[2]);
		$display("%0d mismatches found", error_count);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/cvr_pkg.sv
design/cvr_div.sv
design/cvr_dly.sv
design/collision_velocity_response_2d_unit.sv
tb/sv/collision_velocity_response_2d_unit_tb.sv
